// ----- hw/rtl/gcca_pkg.sv -----
// ----------------------------------------------------------------------------
// gcca_pkg: shared types and constants for the central angle core
// Fixed-point formats, angle limits and the CORDIC constant generators.
// ----------------------------------------------------------------------------
package gcca_pkg;

  // CORDIC datapath width: Q40 values with head room for gain growth
  localparam int CW = 44;

  typedef logic signed [CW-1:0] cw_t;
  typedef logic signed [31:0]   q30_t;

  localparam longint DEG90     = 64'sd377487360;
  localparam longint DEG180    = 64'sd754974720;
  localparam longint DEG360    = 64'sd1509949440;
  localparam longint ANGLE_MAX = 64'sd3373259427;

  localparam logic [23:0] RADIUS_RESET = 24'd6371229;

  // shift-and-subtract unsigned division for the constant generators;
  // gives the remainder when want_rem is set, the quotient otherwise
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den,
                                         input bit want_rem);
    logic [63:0] q;
    logic [63:0] r;
    q = 64'd0;
    r = 64'd0;
    for (int j = 63; j >= 0; j--) begin
      r = {r[62:0], num[j]};
      if (r >= den) begin
        r    = r - den;
        q[j] = 1'b1;
      end
    end
    return want_rem ? r : q;
  endfunction

  // atan(2^-i) in Q62 by the alternating series
  function automatic logic [63:0] atan_pow2_q62(input int unsigned i);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] t;
    int unsigned sh;
    p   = (i <= 62) ? (64'd1 << (62 - i)) : 64'd0;
    sum = 64'd0;
    sh  = 2 * i;
    for (int k = 0; k < 64; k++) begin
      if (p != 64'd0) begin
        t = udiv64(p, 64'(2 * k + 1), 1'b0);
        if ((k % 2) == 1) sum = sum - t;
        else sum = sum + t;
        p = (sh < 64) ? (p >> sh) : 64'd0;
      end
    end
    return sum;
  endfunction

  // atan(1/3) in Q62
  function automatic logic [63:0] atan_third_q62();
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] t;
    p   = udiv64(64'd1 << 62, 64'd3, 1'b0);
    sum = 64'd0;
    for (int k = 0; k < 64; k++) begin
      if (p != 64'd0) begin
        t = udiv64(p, 64'(2 * k + 1), 1'b0);
        if ((k % 2) == 1) sum = sum - t;
        else sum = sum + t;
        p = udiv64(p, 64'd9, 1'b0);
      end
    end
    return sum;
  endfunction

  // pi/4 in Q62
  function automatic logic [63:0] quarter_q62();
    return atan_pow2_q62(1) + atan_third_q62();
  endfunction

  // per-stage CORDIC arctangent in Q40
  function automatic logic [63:0] atan_q40(input int unsigned i);
    logic [63:0] v;
    v = (i == 0) ? quarter_q62() : atan_pow2_q62(i);
    return (v + (64'd1 << 21)) >> 22;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = val;
    r = 64'd0;
    b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // inverse CORDIC gain for n stages, Q40
  function automatic logic [63:0] gain_q40(input int n);
    logic [63:0] g;
    logic [63:0] s;
    logic [63:0] top;
    logic [63:0] rem;
    g = 64'd1 << 62;
    for (int i = 0; i < n; i++) begin
      if (2 * i < 64) g = g + (g >> (2 * i));
    end
    s   = isqrt64(g);
    top = 64'd1 << 63;
    rem = udiv64(top, s, 1'b1);
    return (udiv64(top, s, 1'b0) << 8) + udiv64(rem << 8, s, 1'b0);
  endfunction

  localparam logic [63:0] PI_Q40   = (4 * quarter_q62() + (64'd1 << 21)) >> 22;
  localparam logic [63:0] DEG_COEF = ((4 * quarter_q62()) / 180 + (64'd1 << 22)) >> 23;

  // Q40 to Q30, rounded half up and clamped to +-1.0
  function automatic q30_t to_q30(input cw_t v);
    cw_t r;
    r = (v + cw_t'(512)) >>> 10;
    if (r > cw_t'(64'sd1073741824)) r = cw_t'(64'sd1073741824);
    if (r < -cw_t'(64'sd1073741824)) r = -cw_t'(64'sd1073741824);
    return r[31:0];
  endfunction

  // Q30 product rounded back to Q30
  function automatic q30_t mul30(input q30_t a, input q30_t b);
    logic signed [63:0] p;
    p = a * b;
    p = (p + (64'sd1 <<< 29)) >>> 30;
    return p[31:0];
  endfunction

endpackage

// ----- hw/rtl/gcca_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// gcca_cordic_cell: one CORDIC micro-rotation
// Rotation mode steers on the residual angle, vectoring mode on y.
// ----------------------------------------------------------------------------
module gcca_cordic_cell #(
  parameter int STAGE  = 0,
  parameter bit VECTOR = 1'b0
) (
  input  logic          clk,
  input  logic          en,
  input  gcca_pkg::cw_t x_in,
  input  gcca_pkg::cw_t y_in,
  input  gcca_pkg::cw_t z_in,
  output gcca_pkg::cw_t x_out,
  output gcca_pkg::cw_t y_out,
  output gcca_pkg::cw_t z_out
);
  import gcca_pkg::*;

  localparam logic [63:0] ATAN = atan_q40(STAGE);

  cw_t atan_c;
  cw_t dx;
  cw_t dy;
  logic sel;

  assign atan_c = $signed(ATAN[CW-1:0]);
  assign dx     = y_in >>> STAGE;
  assign dy     = x_in >>> STAGE;
  assign sel    = VECTOR ? !(y_in > cw_t'(0)) : (z_in >= cw_t'(0));

  // micro-rotation, registered
  always_ff @(posedge clk) begin
    if (en) begin
      if (sel) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - atan_c;
      end else begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + atan_c;
      end
    end
  end

endmodule

// ----- hw/rtl/gcca_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// gcca_sqrt_cell: one step of the restoring integer square root
// Resolves one result bit per cell; the trial bit is fixed per position.
// ----------------------------------------------------------------------------
module gcca_sqrt_cell #(
  parameter int SHIFT = 62
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] v_in,
  input  logic [63:0] r_in,
  output logic [63:0] v_out,
  output logic [63:0] r_out
);

  localparam logic [63:0] TRIAL = 64'd1 << SHIFT;

  logic [63:0] tr;

  assign tr = r_in + TRIAL;

  // subtract the trial value when it fits
  always_ff @(posedge clk) begin
    if (en) begin
      if (v_in >= tr) begin
        v_out <= v_in - tr;
        r_out <= (r_in >> 1) + TRIAL;
      end else begin
        v_out <= v_in;
        r_out <= r_in >> 1;
      end
    end
  end

endmodule

// ----- hw/rtl/great_circle_central_angle_core.sv -----
// Accepts one item per cycle while no result is held by out_stall;
// every CORDIC and square-root cell is its own stage.
// The whole pipeline advances unless a result is held by out_stall.
// Reset (rst, synchronous) empties the pipeline and loads the radius register
// with 6371229.
// ----------------------------------------------------------------------------
// great_circle_central_angle_core: great-circle angle and arc distance
// Three rotation CORDIC lanes, Vincenty numerator and denominator, a square
// root chain and a vectoring CORDIC chain, then radius scaling.
// ----------------------------------------------------------------------------
module great_circle_central_angle_core #(
  parameter int CORDIC_STAGES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [29:0] point_a_lat,
  input  logic [31:0] point_a_lon,
  input  logic [29:0] point_b_lat,
  input  logic [31:0] point_b_lon,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] central_angle,
  output logic [33:0] arc_distance,
  output logic        latitude_invalid
);
  import gcca_pkg::*;

  localparam int N  = CORDIC_STAGES;
  localparam int SQ = 32;
  localparam logic [63:0] GAIN = gain_q40(CORDIC_STAGES);

  logic en;
  logic [23:0] sphere_radius;

  // stage valids and flags
  logic v0, v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v12;
  logic i0, i1, i2, i3, i4, i5, i6, i7, i8, i9, i10, i12;
  logic f2, f3, f4;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // radius register
  always_ff @(posedge clk) begin
    if (rst) sphere_radius <= RADIUS_RESET;
    else if (cfg_wr_en) sphere_radius <= cfg_wr_data;
  end

  // input stage: latitude check and raw longitude difference
  logic signed [29:0] la0, lb0;
  logic signed [32:0] d0;
  logic inv_c;

  assign inv_c = ($signed(point_a_lat) < -DEG90) || ($signed(point_a_lat) > DEG90) ||
                 ($signed(point_b_lat) < -DEG90) || ($signed(point_b_lat) > DEG90);

  always_ff @(posedge clk) begin
    if (en) begin
      la0 <= $signed(point_a_lat);
      lb0 <= $signed(point_b_lat);
      d0  <= 33'($signed(point_b_lon)) - 33'($signed(point_a_lon));
      i0  <= inv_c;
    end
  end

  // longitude difference into [-180, 180)
  logic signed [35:0] cand;
  logic signed [30:0] m_c;

  always_comb begin
    m_c  = '0;
    cand = '0;
    for (int k = -3; k <= 3; k++) begin
      cand = 36'(d0) - 36'(longint'(k) * DEG360);
      if (cand >= -DEG180 && cand < DEG180) m_c = cand[30:0];
    end
  end

  logic signed [29:0] la1, lb1;
  logic signed [30:0] m1;

  always_ff @(posedge clk) begin
    if (en) begin
      la1 <= la0;
      lb1 <= lb0;
      m1  <= m_c;
      i1  <= i0;
    end
  end

  // fold the difference into +-90 degrees, remember the cosine sign flip
  logic signed [30:0] m2_c;
  logic f2_c;

  always_comb begin
    m2_c = m1;
    f2_c = 1'b0;
    if (m1 > DEG90) begin
      m2_c = 31'(DEG180) - m1;
      f2_c = 1'b1;
    end else if (m1 < -DEG90) begin
      m2_c = -31'(DEG180) - m1;
      f2_c = 1'b1;
    end
  end

  logic signed [30:0] ang2 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      ang2[0] <= 31'(la1);
      ang2[1] <= 31'(lb1);
      ang2[2] <= m2_c;
      f2      <= f2_c;
      i2      <= i1;
    end
  end

  // degrees to radians: coefficient split in two narrow products
  logic signed [17:0] coef_hi;
  logic signed [17:0] coef_lo;
  logic signed [48:0] ph3 [3];
  logic signed [48:0] pl3 [3];

  assign coef_hi = $signed({1'b0, DEG_COEF[33:17]});
  assign coef_lo = $signed({1'b0, DEG_COEF[16:0]});

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        ph3[l] <= ang2[l] * coef_hi;
        pl3[l] <= ang2[l] * coef_lo;
      end
      f3 <= f2;
      i3 <= i2;
    end
  end

  logic signed [63:0] psum [3];
  cw_t z4 [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      psum[l] = ((64'(ph3[l]) <<< 17) + 64'(pl3[l]) + (64'sd1 <<< 20)) >>> 21;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) z4[l] <= psum[l][CW-1:0];
      f4 <= f3;
      i4 <= i3;
    end
  end

  // rotation CORDIC lanes: lat a, lat b, longitude difference
  cw_t rx [3][N+1];
  cw_t ry [3][N+1];
  cw_t rz [3][N+1];

  genvar gl, gk;
  generate
    for (gl = 0; gl < 3; gl++) begin : g_rot_lane
      assign rx[gl][0] = $signed(GAIN[CW-1:0]);
      assign ry[gl][0] = '0;
      assign rz[gl][0] = z4[gl];
      for (gk = 0; gk < N; gk++) begin : g_rot_cell
        gcca_cordic_cell #(.STAGE(gk), .VECTOR(1'b0)) u_cell (
          .clk  (clk),
          .en   (en),
          .x_in (rx[gl][gk]),
          .y_in (ry[gl][gk]),
          .z_in (rz[gl][gk]),
          .x_out(rx[gl][gk+1]),
          .y_out(ry[gl][gk+1]),
          .z_out(rz[gl][gk+1])
        );
      end
    end
  endgenerate

  logic [N-1:0] rt_v;
  logic [N-1:0] rt_inv;
  logic [N-1:0] rt_flip;

  always_ff @(posedge clk) begin
    if (rst) rt_v <= '0;
    else if (en) rt_v <= {rt_v[N-2:0], v4};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rt_inv  <= {rt_inv[N-2:0], i4};
      rt_flip <= {rt_flip[N-2:0], f4};
    end
  end

  // sines and cosines in Q30
  q30_t c1, s1, c2, s2, cl, sl;

  always_ff @(posedge clk) begin
    if (en) begin
      c1 <= to_q30(rx[0][N]);
      s1 <= to_q30(ry[0][N]);
      c2 <= to_q30(rx[1][N]);
      s2 <= to_q30(ry[1][N]);
      cl <= rt_flip[N-1] ? -to_q30(rx[2][N]) : to_q30(rx[2][N]);
      sl <= to_q30(ry[2][N]);
      i5 <= rt_inv[N-1];
    end
  end

  // first products
  q30_t t1_6, ps1c2, pc1c2, cl6;
  logic signed [63:0] c1s2_6, s1s2_6;

  always_ff @(posedge clk) begin
    if (en) begin
      t1_6   <= mul30(c2, sl);
      ps1c2  <= mul30(s1, c2);
      pc1c2  <= mul30(c1, c2);
      c1s2_6 <= c1 * s2;
      s1s2_6 <= s1 * s2;
      cl6    <= cl;
      i6     <= i5;
    end
  end

  // products with the longitude cosine
  q30_t t1_7;
  logic signed [63:0] q1_7, q2_7, c1s2_7, s1s2_7;

  always_ff @(posedge clk) begin
    if (en) begin
      q1_7   <= ps1c2 * cl6;
      q2_7   <= pc1c2 * cl6;
      c1s2_7 <= c1s2_6;
      s1s2_7 <= s1s2_6;
      t1_7   <= t1_6;
      i7     <= i6;
    end
  end

  // numerator term and denominator
  logic signed [63:0] t2_full, den_full;
  q30_t t1_8;
  logic signed [33:0] t2_8, den8;

  assign t2_full  = (c1s2_7 - q1_7 + (64'sd1 <<< 29)) >>> 30;
  assign den_full = (s1s2_7 + q2_7 + (64'sd1 <<< 29)) >>> 30;

  always_ff @(posedge clk) begin
    if (en) begin
      t1_8 <= t1_7;
      t2_8 <= t2_full[33:0];
      den8 <= den_full[33:0];
      i8   <= i7;
    end
  end

  // squares
  logic signed [63:0] t1sq, t2sq;
  logic dneg9, dneg10;
  logic [32:0] dabs9, dabs10;
  logic signed [33:0] den_neg;

  assign den_neg = -den8;

  always_ff @(posedge clk) begin
    if (en) begin
      t1sq  <= t1_8 * t1_8;
      t2sq  <= t2_8 * t2_8;
      dneg9 <= den8[33];
      dabs9 <= den8[33] ? den_neg[32:0] : den8[32:0];
      i9    <= i8;
    end
  end

  logic [63:0] sum10;

  always_ff @(posedge clk) begin
    if (en) begin
      sum10  <= 64'(t1sq) + 64'(t2sq);
      dneg10 <= dneg9;
      dabs10 <= dabs9;
      i10    <= i9;
    end
  end

  // square root chain
  logic [63:0] sv [SQ+1];
  logic [63:0] sr [SQ+1];

  assign sv[0] = sum10;
  assign sr[0] = '0;

  generate
    for (gk = 0; gk < SQ; gk++) begin : g_sqrt_cell
      gcca_sqrt_cell #(.SHIFT(62 - 2 * gk)) u_cell (
        .clk  (clk),
        .en   (en),
        .v_in (sv[gk]),
        .r_in (sr[gk]),
        .v_out(sv[gk+1]),
        .r_out(sr[gk+1])
      );
    end
  endgenerate

  logic [SQ-1:0] st_v, st_inv, st_dneg;
  logic [32:0] st_dabs [SQ];

  always_ff @(posedge clk) begin
    if (rst) st_v <= '0;
    else if (en) st_v <= {st_v[SQ-2:0], v10};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_inv     <= {st_inv[SQ-2:0], i10};
      st_dneg    <= {st_dneg[SQ-2:0], dneg10};
      st_dabs[0] <= dabs10;
      for (int k = 1; k < SQ; k++) st_dabs[k] <= st_dabs[k-1];
    end
  end

  // vectoring CORDIC chain
  cw_t vx [N+1];
  cw_t vy [N+1];
  cw_t vz [N+1];

  assign vx[0] = $signed(CW'({st_dabs[SQ-1], 10'b0}));
  assign vy[0] = $signed(CW'({sr[SQ][32:0], 10'b0}));
  assign vz[0] = '0;

  generate
    for (gk = 0; gk < N; gk++) begin : g_vec_cell
      gcca_cordic_cell #(.STAGE(gk), .VECTOR(1'b1)) u_cell (
        .clk  (clk),
        .en   (en),
        .x_in (vx[gk]),
        .y_in (vy[gk]),
        .z_in (vz[gk]),
        .x_out(vx[gk+1]),
        .y_out(vy[gk+1]),
        .z_out(vz[gk+1])
      );
    end
  endgenerate

  logic [N-1:0] vt_v, vt_inv, vt_dneg;

  always_ff @(posedge clk) begin
    if (rst) vt_v <= '0;
    else if (en) vt_v <= {vt_v[N-2:0], st_v[SQ-1]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vt_inv  <= {vt_inv[N-2:0], st_inv[SQ-1]};
      vt_dneg <= {vt_dneg[N-2:0], st_dneg[SQ-1]};
    end
  end

  // quadrant fix, rounding to 2^-30 rad and clamping
  cw_t zf, ar;
  logic [31:0] ang_c;
  logic [31:0] ang12;

  always_comb begin
    zf = vt_dneg[N-1] ? ($signed(PI_Q40[CW-1:0]) - vz[N]) : vz[N];
    ar = (zf + cw_t'(512)) >>> 10;
    if (ar <= cw_t'(0)) ang_c = '0;
    else if (ar > cw_t'(ANGLE_MAX)) ang_c = ANGLE_MAX[31:0];
    else ang_c = ar[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang12 <= ang_c;
      i12   <= vt_inv[N-1];
    end
  end

  // radius scaling and output register
  logic [56:0] dist_c;

  assign dist_c = 57'(sphere_radius) * 57'(ang12) + (57'd1 << 21);

  always_ff @(posedge clk) begin
    if (en) begin
      central_angle    <= i12 ? '0 : ang12;
      arc_distance     <= i12 ? '0 : dist_c[55:22];
      latitude_invalid <= i12;
    end
  end

  // valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0; v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0;
      v10 <= 1'b0; v12 <= 1'b0; out_valid <= 1'b0;
    end else if (en) begin
      v0 <= in_valid; v1 <= v0; v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= rt_v[N-1]; v6 <= v5; v7 <= v6; v8 <= v7; v9 <= v8;
      v10 <= v9; v12 <= vt_v[N-1]; out_valid <= v12;
    end
  end

endmodule

// ----- hw/rtl/gcca_port_checker.sv -----
// ----------------------------------------------------------------------------
// gcca_port_checker: port-level checks for the central angle core
// Watches the handshakes and result fields; attached by bind.
// ----------------------------------------------------------------------------
module gcca_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] central_angle,
  input logic [33:0] arc_distance,
  input logic        latitude_invalid
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // input only stalls behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // invalid latitude gives zero results
  a_inv_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && latitude_invalid |-> central_angle == 32'd0 && arc_distance == 34'd0)
    else $error("nonzero result on invalid latitude");

  // zero angle gives zero distance; angle never above pi
  a_angle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> central_angle <= 32'd3373259427 &&
                  (central_angle != 32'd0 || arc_distance == 34'd0))
    else $error("angle out of range or distance inconsistent");

endmodule

bind great_circle_central_angle_core gcca_port_checker u_port_checker (
  .clk             (clk),
  .rst             (rst),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .central_angle   (central_angle),
  .arc_distance    (arc_distance),
  .latitude_invalid(latitude_invalid)
);
